// ===== hw/rtl/hsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared types and fixed-point constants of the hsv to rgb converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvc_pkg;

	localparam int FRAC_BITS    = 8;
	localparam int HUE_SUB_BITS = 6;

	localparam int HUE_W  = 15;
	localparam int FRAC_W = 9;
	localparam int CH_W   = 8;

	localparam int ONE         = 1 << FRAC_BITS;
	localparam int SECTOR_SPAN = 60 << HUE_SUB_BITS;
	localparam int FULL_TURN   = 360 << HUE_SUB_BITS;

	// one sector in hue units times one, the full-scale channel factor
	localparam int UNIT_FACTOR = ONE * SECTOR_SPAN;

	localparam int REM_W    = $clog2(SECTOR_SPAN + 1);
	localparam int FACTOR_W = $clog2(UNIT_FACTOR + 1);
	localparam int MUL_W    = FRAC_W + FACTOR_W - 1;
	localparam int SCALED_W = MUL_W + CH_W;

	// channel = floor(m * 255 / (ONE * ONE * SECTOR_SPAN))
	// denominator = 2^DEN_SHIFT * 15, the shift is taken first
	localparam int DEN_SHIFT = 2 * FRAC_BITS + HUE_SUB_BITS + 2;
	localparam int QUOT_W    = SCALED_W - DEN_SHIFT;

	// floor(z / 15) = (z * RECIP) >> RECIP_SHIFT for z below 4096
	localparam int RECIP       = 4370;
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = 13;
	localparam int RPROD_W     = QUOT_W + RECIP_W;

	typedef logic [HUE_W-1:0]  hue_t;
	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [CH_W-1:0]   chan_t;

	typedef enum logic [2:0] {
		SECT_RED_YELLOW,
		SECT_YELLOW_GREEN,
		SECT_GREEN_CYAN,
		SECT_CYAN_BLUE,
		SECT_BLUE_MAGENTA,
		SECT_MAGENTA_RED
	} sector_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsvc_hsv_if.sv =====
// ----------------------------------------------------------------------------
// hsvc_hsv_if
// Valid/ready channel carrying one hsv color per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvc_hsv_if;
	import hsvc_pkg::*;

	logic  valid;
	logic  ready;
	hue_t  hue;
	frac_t saturation;
	frac_t brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hsvc_rgb_if.sv =====
// ----------------------------------------------------------------------------
// hsvc_rgb_if
// Valid/ready channel carrying one 8-bit rgb color per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvc_rgb_if;
	import hsvc_pkg::*;

	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hsv_to_rgb_converter_unit.sv =====
// path: an accepted hsv beat passes stage registers s1 to s6 before it leaves as its rgb beat
// throughput: one color per cycle; the six register stages move together
// and hold as a whole only while a finished result waits on the output
// reset: arst_n clears the stage valid bits at once, payload is not reset
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Six-sector hsv to rgb conversion in fixed point, exact truncation to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit (
	input wire logic   clk,
	input wire logic   arst_n,
	hsvc_hsv_if.sink   hsv,
	hsvc_rgb_if.source rgb
);
	import hsvc_pkg::*;

	logic advance;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	// stage 1: clamp, sector, remainder
	sector_t          sector_s1;
	logic [REM_W-1:0] rem_s1;
	frac_t            sat_s1, val_s1;

	// stage 2: saturation products
	sector_t             sector_s2;
	logic [FACTOR_W-1:0] sq_s2, st_s2, fp_s2;
	frac_t               val_s2;

	// stage 3: routed channel factors
	logic [FACTOR_W-1:0] fr_s3, fg_s3, fb_s3;
	frac_t               val_s3;

	// stage 4: value times factor
	logic [MUL_W-1:0] mr_s4, mg_s4, mb_s4;

	// stage 5: scaled by 255, low denominator bits dropped
	logic [QUOT_W-1:0] zr_s5, zg_s5, zb_s5;

	// stage 6: divided by 15
	chan_t r_s6, g_s6, b_s6;

	assign advance   = !valid_s6 || rgb.ready;
	assign hsv.ready = advance;

	// stage 1 logic
	hue_t             hue_w;
	frac_t            sat_w, val_w;
	sector_t          sector_w;
	hue_t             base_w;

	always_comb begin
		hue_w = (hsv.hue >= HUE_W'(FULL_TURN)) ? '0 : hsv.hue;
		sat_w = (hsv.saturation > FRAC_W'(ONE)) ? FRAC_W'(ONE) : hsv.saturation;
		val_w = (hsv.brightness > FRAC_W'(ONE)) ? FRAC_W'(ONE) : hsv.brightness;
		priority if (hue_w >= HUE_W'(5 * SECTOR_SPAN)) begin
			sector_w = SECT_MAGENTA_RED;
			base_w   = HUE_W'(5 * SECTOR_SPAN);
		end else if (hue_w >= HUE_W'(4 * SECTOR_SPAN)) begin
			sector_w = SECT_BLUE_MAGENTA;
			base_w   = HUE_W'(4 * SECTOR_SPAN);
		end else if (hue_w >= HUE_W'(3 * SECTOR_SPAN)) begin
			sector_w = SECT_CYAN_BLUE;
			base_w   = HUE_W'(3 * SECTOR_SPAN);
		end else if (hue_w >= HUE_W'(2 * SECTOR_SPAN)) begin
			sector_w = SECT_GREEN_CYAN;
			base_w   = HUE_W'(2 * SECTOR_SPAN);
		end else if (hue_w >= HUE_W'(SECTOR_SPAN)) begin
			sector_w = SECT_YELLOW_GREEN;
			base_w   = HUE_W'(SECTOR_SPAN);
		end else begin
			sector_w = SECT_RED_YELLOW;
			base_w   = '0;
		end
	end

	// stage 2 logic
	logic [REM_W-1:0]        comp_w;
	frac_t                   inv_s_w;
	logic [FRAC_W+REM_W-1:0] prod_q_w, prod_t_w, prod_p_w;

	always_comb begin
		comp_w   = REM_W'(SECTOR_SPAN) - rem_s1;
		inv_s_w  = FRAC_W'(ONE) - sat_s1;
		prod_q_w = {{REM_W{1'b0}}, sat_s1} * {{FRAC_W{1'b0}}, rem_s1};
		prod_t_w = {{REM_W{1'b0}}, sat_s1} * {{FRAC_W{1'b0}}, comp_w};
		prod_p_w = {{REM_W{1'b0}}, inv_s_w} * (FRAC_W + REM_W)'(SECTOR_SPAN);
	end

	// stage 3 logic: q, t and v factors, routed by sector
	logic [FACTOR_W-1:0] fq_w, ft_w, fv_w;
	logic [FACTOR_W-1:0] fr_w, fg_w, fb_w;

	always_comb begin
		fv_w = FACTOR_W'(UNIT_FACTOR);
		fq_w = fv_w - sq_s2;
		ft_w = fv_w - st_s2;
		unique case (sector_s2)
			SECT_RED_YELLOW:   begin fr_w = fv_w;  fg_w = ft_w;  fb_w = fp_s2; end
			SECT_YELLOW_GREEN: begin fr_w = fq_w;  fg_w = fv_w;  fb_w = fp_s2; end
			SECT_GREEN_CYAN:   begin fr_w = fp_s2; fg_w = fv_w;  fb_w = ft_w;  end
			SECT_CYAN_BLUE:    begin fr_w = fp_s2; fg_w = fq_w;  fb_w = fv_w;  end
			SECT_BLUE_MAGENTA: begin fr_w = ft_w;  fg_w = fp_s2; fb_w = fv_w;  end
			default:           begin fr_w = fv_w;  fg_w = fp_s2; fb_w = fq_w;  end
		endcase
	end

	// stage 4 logic
	logic [FRAC_W+FACTOR_W-1:0] pr_w, pg_w, pb_w;

	always_comb begin
		pr_w = {{FACTOR_W{1'b0}}, val_s3} * {{FRAC_W{1'b0}}, fr_s3};
		pg_w = {{FACTOR_W{1'b0}}, val_s3} * {{FRAC_W{1'b0}}, fg_s3};
		pb_w = {{FACTOR_W{1'b0}}, val_s3} * {{FRAC_W{1'b0}}, fb_s3};
	end

	// stage 5 logic: times 255 as a shift and subtract
	logic [SCALED_W-1:0] wr_w, wg_w, wb_w;

	always_comb begin
		wr_w = {mr_s4, {CH_W{1'b0}}} - {{CH_W{1'b0}}, mr_s4};
		wg_w = {mg_s4, {CH_W{1'b0}}} - {{CH_W{1'b0}}, mg_s4};
		wb_w = {mb_s4, {CH_W{1'b0}}} - {{CH_W{1'b0}}, mb_s4};
	end

	// stage 6 logic: reciprocal multiply for the divide by 15
	logic [RPROD_W-1:0] qr_w, qg_w, qb_w;

	always_comb begin
		qr_w = {{RECIP_W{1'b0}}, zr_s5} * RPROD_W'(RECIP);
		qg_w = {{RECIP_W{1'b0}}, zg_s5} * RPROD_W'(RECIP);
		qb_w = {{RECIP_W{1'b0}}, zb_s5} * RPROD_W'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= hsv.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sector_s1 <= sector_w;
			rem_s1    <= REM_W'(hue_w - base_w);
			sat_s1    <= sat_w;
			val_s1    <= val_w;

			sector_s2 <= sector_s1;
			sq_s2     <= prod_q_w[FACTOR_W-1:0];
			st_s2     <= prod_t_w[FACTOR_W-1:0];
			fp_s2     <= prod_p_w[FACTOR_W-1:0];
			val_s2    <= val_s1;

			fr_s3  <= fr_w;
			fg_s3  <= fg_w;
			fb_s3  <= fb_w;
			val_s3 <= val_s2;

			mr_s4 <= pr_w[MUL_W-1:0];
			mg_s4 <= pg_w[MUL_W-1:0];
			mb_s4 <= pb_w[MUL_W-1:0];

			zr_s5 <= wr_w[SCALED_W-1:DEN_SHIFT];
			zg_s5 <= wg_w[SCALED_W-1:DEN_SHIFT];
			zb_s5 <= wb_w[SCALED_W-1:DEN_SHIFT];

			r_s6 <= qr_w[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
			g_s6 <= qg_w[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
			b_s6 <= qb_w[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
		end
	end

	assign rgb.valid = valid_s6;
	assign rgb.red   = r_s6;
	assign rgb.green = g_s6;
	assign rgb.blue  = b_s6;

endmodule

`default_nettype wire

// ===== hw/rtl/hsvc_checker.sv =====
// ----------------------------------------------------------------------------
// hsvc_checker
// Port-level checks of the hsv to rgb converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [3*8-1:0]    out_data
);

	// a waiting beat keeps its valid
	a_out_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("rgb valid dropped while stalled");

	// a waiting beat keeps its color
	a_out_data_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("rgb color changed while stalled");

	// an open output always lets the pipeline move
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("hsv ready low with rgb ready high");

	// a stalled result holds every stage, so no new beat may enter
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("hsv beat taken while rgb stalled");

endmodule

bind hsv_to_rgb_converter_unit hsvc_checker u_hsvc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (hsv.ready),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.out_data  ({rgb.red, rgb.green, rgb.blue})
);

`default_nettype wire

// ===== verif/tb_hsv_rgb_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_rgb_check
// Watches both channels of the hsv to rgb converter. Each accepted hsv beat
// is turned into an expected rgb color by an exact integer model. Each
// accepted rgb beat is compared field by field with the oldest expected color.
// ----------------------------------------------------------------------------

module tb_hsv_rgb_check (
	input  logic clk,
	input  logic arst_n,
	hsvc_hsv_if  hsv,
	hsvc_rgb_if  rgb,
	output int   mismatches,
	output int   pending,
	output int   colors_in,
	output int   colors_out
);
	import hsvc_pkg::*;

	localparam longint unsigned UNIT_Q      = 256;
	localparam longint unsigned HUE_SECTOR  = 3840;
	localparam longint unsigned HUE_TURN    = 6 * HUE_SECTOR;
	localparam longint unsigned CHAN_DENOM  = UNIT_Q * UNIT_Q * HUE_SECTOR;
	localparam int              SHOWN_ERRS  = 10;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_color_t;

	rgb_color_t expected_colors[$];
	int mismatch_count = 0;
	int in_count       = 0;
	int out_count      = 0;

	assign mismatches = mismatch_count;
	assign pending    = expected_colors.size();
	assign colors_in  = in_count;
	assign colors_out = out_count;

	// numerator is over unit * unit * sector, scaled by 255 and truncated
	function automatic chan_t scale_to_chan(longint unsigned num);
		longint unsigned c;
		c = (num * 255) / CHAN_DENOM;
		if (c > 255) begin
			c = 255;
		end
		return chan_t'(c);
	endfunction

	function automatic rgb_color_t predict_rgb(hue_t hue_in, frac_t sat_in, frac_t val_in);
		longint unsigned h, s, v, sect, offs;
		longint unsigned full_v, low_v, fall_v, rise_v, r, g, b;
		rgb_color_t c;
		h = hue_in;
		s = sat_in;
		v = val_in;
		if (s > UNIT_Q) begin
			s = UNIT_Q;
		end
		if (v > UNIT_Q) begin
			v = UNIT_Q;
		end
		full_v = v * UNIT_Q * HUE_SECTOR;
		if (s == 0) begin
			r = full_v;
			g = full_v;
			b = full_v;
		end else begin
			if (h >= HUE_TURN) begin
				h = 0;
			end
			sect   = h / HUE_SECTOR;
			offs   = h - sect * HUE_SECTOR;
			low_v  = v * (UNIT_Q - s) * HUE_SECTOR;
			fall_v = v * (UNIT_Q * HUE_SECTOR - s * offs);
			rise_v = v * (UNIT_Q * HUE_SECTOR - s * (HUE_SECTOR - offs));
			case (sector_t'(sect))
				SECT_RED_YELLOW: begin
					r = full_v; g = rise_v; b = low_v;
				end
				SECT_YELLOW_GREEN: begin
					r = fall_v; g = full_v; b = low_v;
				end
				SECT_GREEN_CYAN: begin
					r = low_v; g = full_v; b = rise_v;
				end
				SECT_CYAN_BLUE: begin
					r = low_v; g = fall_v; b = full_v;
				end
				SECT_BLUE_MAGENTA: begin
					r = rise_v; g = low_v; b = full_v;
				end
				default: begin
					r = full_v; g = low_v; b = fall_v;
				end
			endcase
		end
		c.red   = scale_to_chan(r);
		c.green = scale_to_chan(g);
		c.blue  = scale_to_chan(b);
		return c;
	endfunction

	always @(posedge clk) begin
		rgb_color_t want;
		if (arst_n) begin
			// output side first so a color is never matched against its own beat
			if (rgb.valid && rgb.ready) begin
				out_count++;
				if (expected_colors.size() == 0) begin
					if (mismatch_count < SHOWN_ERRS) begin
						$display("%0t: unexpected rgb beat r=%0d g=%0d b=%0d", $time,
							rgb.red, rgb.green, rgb.blue);
					end
					mismatch_count++;
				end else begin
					want = expected_colors.pop_front();
					if (rgb.red !== want.red || rgb.green !== want.green ||
							rgb.blue !== want.blue) begin
						if (mismatch_count < SHOWN_ERRS) begin
							$display("%0t: rgb beat %0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								$time, out_count, want.red, want.green, want.blue,
								rgb.red, rgb.green, rgb.blue);
						end
						mismatch_count++;
					end
				end
			end
			if (hsv.valid && hsv.ready) begin
				in_count++;
				expected_colors.push_back(predict_rgb(hsv.hue, hsv.saturation, hsv.brightness));
			end
		end
	end

endmodule

// ===== verif/tb_hsv_to_rgb_converter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_unit
// Drives hsv colors into the converter: directed corners of hue, saturation
// and value first, then random colors under several idle and stall mixes.
// Results are checked by tb_hsv_rgb_check; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter_unit;
	import hsvc_pkg::*;

	localparam int RANDOM_PER_PHASE = 275;
	localparam int HANG_LIMIT       = 4000;
	localparam int DRAIN_CYCLES     = 20;
	localparam int HUE_SECTOR       = 3840;
	localparam int HUE_TURN         = 23040;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   gap_pct     = 0;
	int   stall_pct   = 0;
	int   idle_cycles = 0;
	int   mismatches, pending, colors_in, colors_out;

	hsvc_hsv_if hsv_ch ();
	hsvc_rgb_if rgb_ch ();

	hsv_to_rgb_converter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	tb_hsv_rgb_check u_color_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv        (hsv_ch),
		.rgb        (rgb_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.colors_in  (colors_in),
		.colors_out (colors_out)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rgb_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// ends a hung run: no beat on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= HANG_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d colors pending",
					idle_cycles, pending);
				$display("tb_hsv_to_rgb_converter_unit: FAIL");
				$finish;
			end
		end
	end

	task automatic send_hsv(input int h, input int s, input int v);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			hsv_ch.valid <= 1'b0;
			@(posedge clk);
		end
		hsv_ch.valid      <= 1'b1;
		hsv_ch.hue        <= hue_t'(h);
		hsv_ch.saturation <= frac_t'(s);
		hsv_ch.brightness <= frac_t'(v);
		@(posedge clk);
		while (!hsv_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// mostly in range, with corners and values that clamp to one
	function automatic int pick_fraction();
		int f;
		case ($urandom_range(19))
			0, 1, 2: f = $urandom_range(257, 511);
			3, 4, 5: begin
				case ($urandom_range(3))
					0:       f = 0;
					1:       f = 1;
					2:       f = 255;
					default: f = 256;
				endcase
			end
			default: f = $urandom_range(0, 256);
		endcase
		return f;
	endfunction

	initial begin
		int h;
		hsv_ch.valid      = 1'b0;
		hsv_ch.hue        = '0;
		hsv_ch.saturation = '0;
		hsv_ch.brightness = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gray levels, wrapped hue with no saturation
		send_hsv(0, 0, 0);
		send_hsv(0, 0, 256);
		send_hsv(32767, 0, 511);
		send_hsv(12000, 0, 137);
		// pure hues at every sector edge, full wrap and beyond
		send_hsv(0, 256, 256);
		send_hsv(3839, 256, 256);
		send_hsv(3840, 256, 256);
		send_hsv(7680, 256, 256);
		send_hsv(11520, 256, 256);
		send_hsv(15360, 256, 256);
		send_hsv(19200, 256, 256);
		send_hsv(23039, 256, 256);
		send_hsv(23040, 256, 256);
		send_hsv(32767, 511, 511);
		// mid-sector fractions and clamped fields
		send_hsv(1920, 128, 200);
		send_hsv(5760, 1, 256);
		send_hsv(9600, 255, 255);
		send_hsv(13440, 300, 400);
		send_hsv(17280, 256, 1);
		send_hsv(21120, 511, 128);
		send_hsv(24000, 100, 100);
		send_hsv(16384, 256, 0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 47; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 47; end
				default: begin gap_pct = 25; stall_pct = 25; end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				case ($urandom_range(19))
					0, 1: h = $urandom_range(HUE_TURN, 32767);
					2, 3: h = $urandom_range(1, 6) * HUE_SECTOR - 1 + $urandom_range(0, 2);
					default: h = $urandom_range(0, HUE_TURN - 1);
				endcase
				send_hsv(h, pick_fraction(), pick_fraction());
			end
		end
		hsv_ch.valid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d hsv colors into %0d rgb colors: gray, sector edges, wrap",
			colors_in, colors_out);
		$display("and clamp corners, then random colors under four idle/stall mixes");
		if (mismatches == 0 && pending == 0) begin
			$display("tb_hsv_to_rgb_converter_unit: PASS");
		end else begin
			$display("%0d mismatches, %0d colors never came out", mismatches, pending);
			$display("tb_hsv_to_rgb_converter_unit: FAIL");
		end
		$finish;
	end

endmodule
